[src/ffid_pkg.sv]
// Shared types and codes for the form field id extractor.
package ffid_pkg;

    localparam int STATUS_W = 2;
    localparam int ID_W     = 63;

    // Marker that follows the decoded character of a token
    localparam logic [1:0] MK_NONE = 2'd0;
    localparam logic [1:0] MK_AMP  = 2'd1;
    localparam logic [1:0] MK_EQ   = 2'd2;
    localparam logic [1:0] MK_HALT = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_ID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;

    // One classified body byte: at most one decoded character that matters,
    // then a pair marker, then the end-of-body flag.
    typedef struct packed {
        logic       has_char;
        logic [7:0] ch;
        logic [1:0] marker;
        logic       last;
    } tok_t;

endpackage

[src/ffid_body_if.sv]
// Input channel: raw body bytes.
interface ffid_body_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last;

    modport source (output valid, output in_byte, output last, input ready);
    modport sink (input valid, input in_byte, input last, output ready);
endinterface

[src/ffid_result_if.sv]
// Output channel: one result item per body.
interface ffid_result_if;
    import ffid_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id_value;

    modport source (output valid, output status, output id_value, input ready);
    modport sink (input valid, input status, input id_value, output ready);
endinterface

[src/ffid_front.sv]
// Front end: pair splitting and percent decoding of raw bytes into tokens.
module ffid_front (
    input  logic           clk,
    input  logic           rst_n,
    ffid_body_if.sink      body,
    input  logic           q_full,
    output logic           push,
    output ffid_pkg::tok_t tok
);
    import ffid_pkg::*;

    logic       halted_reg, halted_next;
    logic       in_value_reg, in_value_next;
    logic [1:0] esc_cnt_reg, esc_cnt_next;
    logic [7:0] esc_digit_reg, esc_digit_next;
    logic       accept;
    logic [7:0] b;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
                 (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c - 8'h30;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = c - 8'h57;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = c - 8'h37;
        end
        hex_val = v[3:0];
    endfunction

    assign body.ready = !q_full;
    assign accept     = body.valid && !q_full;
    assign b          = body.in_byte;

    always_comb
    begin
        halted_next    = halted_reg;
        in_value_next  = in_value_reg;
        esc_cnt_next   = esc_cnt_reg;
        esc_digit_next = esc_digit_reg;
        tok            = '0;
        tok.marker     = MK_NONE;
        tok.last       = body.last;

        if (!halted_reg)
        begin
            if (b == 8'h00 || b == 8'h26 || (b == 8'h3d && !in_value_reg))
            begin
                // pair boundary: a pending escape flushes as a literal '%'
                tok.has_char   = (esc_cnt_reg != 2'd0);
                tok.ch         = 8'h25;
                esc_cnt_next   = 2'd0;
                esc_digit_next = 8'h00;
                if (b == 8'h00)
                begin
                    tok.marker  = MK_HALT;
                    halted_next = 1'b1;
                end
                else if (b == 8'h26)
                begin
                    tok.marker    = MK_AMP;
                    in_value_next = 1'b0;
                end
                else
                begin
                    tok.marker    = MK_EQ;
                    in_value_next = 1'b1;
                end
            end
            else if (esc_cnt_reg == 2'd1 && is_hex(b))
            begin
                esc_digit_next = b;
                esc_cnt_next   = 2'd2;
            end
            else if (esc_cnt_reg == 2'd2 && is_hex(b))
            begin
                tok.has_char   = 1'b1;
                tok.ch         = {hex_val(esc_digit_reg), hex_val(b)};
                esc_cnt_next   = 2'd0;
                esc_digit_next = 8'h00;
            end
            else if (esc_cnt_reg != 2'd0)
            begin
                // broken escape: only the literal '%' can still decide anything
                tok.has_char   = 1'b1;
                tok.ch         = 8'h25;
                esc_cnt_next   = (b == 8'h25) ? 2'd1 : 2'd0;
                esc_digit_next = 8'h00;
            end
            else if (b == 8'h25)
            begin
                esc_cnt_next = 2'd1;
            end
            else
            begin
                tok.has_char = 1'b1;
                tok.ch       = (b == 8'h2b) ? 8'h20 : b;
            end

            if (body.last && esc_cnt_next != 2'd0)
            begin
                tok.has_char = 1'b1;
                tok.ch       = 8'h25;
            end
        end

        if (body.last)
        begin
            halted_next    = 1'b0;
            in_value_next  = 1'b0;
            esc_cnt_next   = 2'd0;
            esc_digit_next = 8'h00;
        end
    end

    assign push = accept && (tok.has_char || tok.marker != MK_NONE || tok.last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halted_reg    <= 1'b0;
            in_value_reg  <= 1'b0;
            esc_cnt_reg   <= 2'd0;
            esc_digit_reg <= 8'h00;
        end
        else if (accept)
        begin
            halted_reg    <= halted_next;
            in_value_reg  <= in_value_next;
            esc_cnt_reg   <= esc_cnt_next;
            esc_digit_reg <= esc_digit_next;
        end
    end

endmodule

[src/ffid_fifo.sv]
// Small flop-based token queue between front and back ends.
module ffid_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ffid_pkg::tok_t wdata,
    output logic           full,
    input  logic           pop,
    output logic           rvalid,
    output ffid_pkg::tok_t rdata
);
    import ffid_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tok_t          mem_reg [DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign rvalid  = (count_reg != '0);
    assign rdata   = mem_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && rvalid;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

[src/ffid_back.sv]
// Back end: key match, number parse and the result register.
module ffid_back #(
    parameter int VALUE_BITS = 63
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  ffid_pkg::tok_t q_tok,
    output logic           pop,
    ffid_result_if.source  result
);
    import ffid_pkg::*;

    localparam logic [1:0] PH_KEY   = 2'd0;
    localparam logic [1:0] PH_IDVAL = 2'd1;
    localparam logic [1:0] PH_SKIP  = 2'd2;
    localparam logic [1:0] PH_HALT  = 2'd3;

    localparam logic [2:0] NP_LEAD   = 3'd0;
    localparam logic [2:0] NP_SIGN   = 3'd1;
    localparam logic [2:0] NP_DIGITS = 3'd2;
    localparam logic [2:0] NP_BAD    = 3'd3;
    localparam logic [2:0] NP_END    = 3'd4;

    localparam logic [7:0] KEY_CH0 = 8'h69;
    localparam logic [7:0] KEY_CH1 = 8'h64;

    localparam int PW = VALUE_BITS + 4;

    logic [1:0]            ph_reg, ph_next;
    logic [1:0]            kpos_reg, kpos_next;
    logic                  kmatch_reg, kmatch_next;
    logic                  kcut_reg, kcut_next;
    logic [2:0]            np_reg, np_next;
    logic                  neg_reg, neg_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic                  sat_reg, sat_next;
    logic                  idf_reg, idf_next;

    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;

    logic [PW-1:0]         acc_ext, prod;
    logic [7:0]            c;
    logic                  is_digit, is_space;

    assign pop      = q_valid && (!q_tok.last || !out_valid_reg || result.ready);
    assign c        = q_tok.ch;
    assign is_digit = (c >= 8'h30) && (c <= 8'h39);
    assign is_space = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
    assign acc_ext  = PW'(acc_reg);
    assign prod     = (acc_ext << 3) + (acc_ext << 1) + PW'(c[3:0]);

    always_comb
    begin
        ph_next     = ph_reg;
        kpos_next   = kpos_reg;
        kmatch_next = kmatch_reg;
        kcut_next   = kcut_reg;
        np_next     = np_reg;
        neg_next    = neg_reg;
        acc_next    = acc_reg;
        sat_next    = sat_reg;
        idf_next    = idf_reg;
        status_next = ST_NO_ID;
        value_next  = '0;

        if (q_tok.has_char && ph_reg == PH_KEY && !kcut_reg)
        begin
            if (c == 8'h00)
            begin
                kcut_next = 1'b1;
            end
            else
            begin
                if (kpos_reg >= 2'd2 || (kpos_reg == 2'd0 && c != KEY_CH0) ||
                    (kpos_reg == 2'd1 && c != KEY_CH1))
                begin
                    kmatch_next = 1'b0;
                end
                if (kpos_reg != 2'd3)
                begin
                    kpos_next = kpos_reg + 2'd1;
                end
            end
        end
        else if (q_tok.has_char && ph_reg == PH_IDVAL && np_reg != NP_BAD &&
                 np_reg != NP_END)
        begin
            if (c == 8'h00)
            begin
                np_next = (np_reg == NP_DIGITS) ? NP_END : NP_BAD;
            end
            else if (is_digit)
            begin
                np_next = NP_DIGITS;
                if (!sat_reg)
                begin
                    if (prod[PW-1:VALUE_BITS] != '0)
                    begin
                        acc_next = '1;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = prod[VALUE_BITS-1:0];
                    end
                end
            end
            else if (np_reg == NP_LEAD && is_space)
            begin
                np_next = NP_LEAD;
            end
            else if (np_reg == NP_LEAD && (c == 8'h2b || c == 8'h2d))
            begin
                neg_next = (c == 8'h2d);
                np_next  = NP_SIGN;
            end
            else
            begin
                np_next = NP_BAD;
            end
        end

        unique case (q_tok.marker)
            MK_NONE:
            begin
            end
            MK_AMP:
            begin
                if (ph_reg == PH_IDVAL)
                begin
                    ph_next = PH_HALT;
                end
                else if (ph_reg != PH_HALT)
                begin
                    ph_next     = PH_KEY;
                    kpos_next   = 2'd0;
                    kmatch_next = 1'b1;
                    kcut_next   = 1'b0;
                end
            end
            MK_EQ:
            begin
                if (ph_reg == PH_KEY)
                begin
                    if (kmatch_next && kpos_next == 2'd2)
                    begin
                        idf_next = 1'b1;
                        ph_next  = PH_IDVAL;
                    end
                    else
                    begin
                        ph_next = PH_SKIP;
                    end
                end
            end
            MK_HALT:
            begin
                ph_next = PH_HALT;
            end
            default:
            begin
            end
        endcase

        if (q_tok.last)
        begin
            if (!idf_next)
            begin
                status_next = ST_NO_ID;
            end
            else if ((np_next == NP_DIGITS || np_next == NP_END) && !neg_next &&
                     acc_next != '0)
            begin
                status_next = ST_OK;
                value_next  = acc_next;
            end
            else
            begin
                status_next = ST_BAD;
            end
            // fresh body follows
            ph_next     = PH_KEY;
            kpos_next   = 2'd0;
            kmatch_next = 1'b1;
            kcut_next   = 1'b0;
            np_next     = NP_LEAD;
            neg_next    = 1'b0;
            acc_next    = '0;
            sat_next    = 1'b0;
            idf_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg        <= PH_KEY;
            kpos_reg      <= 2'd0;
            kmatch_reg    <= 1'b1;
            kcut_reg      <= 1'b0;
            np_reg        <= NP_LEAD;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            sat_reg       <= 1'b0;
            idf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                ph_reg     <= ph_next;
                kpos_reg   <= kpos_next;
                kmatch_reg <= kmatch_next;
                kcut_reg   <= kcut_next;
                np_reg     <= np_next;
                neg_reg    <= neg_next;
                acc_reg    <= acc_next;
                sat_reg    <= sat_next;
                idf_reg    <= idf_next;
            end
            if (pop && q_tok.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && q_tok.last)
        begin
            status_reg <= status_next;
            value_reg  <= value_next;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.status   = status_reg;
    assign result.id_value = ID_W'(value_reg);

endmodule

[src/form_field_id_extractor.sv]
// Top level of the form field id extractor.
//
// Usage: raw bytes of a URL-encoded form body enter on body, one item per
// byte, with last set on the final byte. For each body exactly one item
// leaves on result: status (0 id found, 1 no id pair, 2 id value invalid)
// and id_value, which is nonzero only with status 0.
// Throughput: one byte per cycle while the queue has room; the front end
// decodes a byte into a token in the cycle it is accepted and the back end
// retires one token per cycle from a four-entry queue unless a result stalls it.
// Output path: the token of the byte with last is written into the queue, and
// the result register loads status and id_value when the back end pops it.
// Reset: rst_n clears all parse state and empties the queue; the first
// byte after reset starts a new body, as does the byte after each last.
// Stall: a waiting result holds the back end only when the next token also
// ends a body; bytes keep flowing into the queue until it fills, and then
// body.ready drops.
module form_field_id_extractor #(
    parameter int VALUE_BITS = 63
) (
    input  logic          clk,
    input  logic          rst_n,
    ffid_body_if.sink     body,
    ffid_result_if.source result
);
    import ffid_pkg::*;

    localparam int QUEUE_DEPTH = 4;

    tok_t front_tok;
    tok_t q_tok;
    logic push;
    logic q_full;
    logic q_valid;
    logic pop;

    ffid_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .body   (body),
        .q_full (q_full),
        .push   (push),
        .tok    (front_tok)
    );

    ffid_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  (front_tok),
        .full   (q_full),
        .pop    (pop),
        .rvalid (q_valid),
        .rdata  (q_tok)
    );

    ffid_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_tok   (q_tok),
        .pop     (pop),
        .result  (result)
    );

endmodule

[test/form_field_id_extractor_tb.sv]
// Testbench for form_field_id_extractor: directed and random form bodies checked against a byte-level predictor.
`timescale 1ns / 100ps

module form_field_id_extractor_tb;
    import ffid_pkg::*;

    localparam int          LIMIT_CYCLES = 200000;
    localparam logic [63:0] ID_MAX       = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {IN_KEY, IN_ID_VALUE, IN_OTHER_VALUE, HALTED} pair_phase_e;
    typedef enum logic [2:0] {NUM_LEAD, NUM_SIGNED, NUM_DIGITS, NUM_BAD, NUM_ENDED} num_phase_e;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id_value;
    } id_outcome_t;

    // Decodes the body byte by byte and keeps the outcome of every finished body.
    class form_id_tracker;
        id_outcome_t outcomes[$];
        int          mismatches;
        int          bytes_seen;
        int          bodies_seen;
        int          ok_count;
        int          no_id_count;
        int          bad_count;

        pair_phase_e pair_phase;
        logic [1:0]  esc_count;
        logic [7:0]  esc_digit;
        logic [1:0]  key_pos;
        bit          key_ok;
        bit          key_cut;
        num_phase_e  num_phase;
        bit          num_neg;
        logic [63:0] num_acc;
        bit          num_sat;
        bit          id_seen;

        function new();
            mismatches = 0;
            bytes_seen = 0;
            bodies_seen = 0;
            ok_count = 0;
            no_id_count = 0;
            bad_count = 0;
            clear_body();
        endfunction

        function void clear_key();
            key_pos = 2'd0;
            key_ok = 1'b1;
            key_cut = 1'b0;
        endfunction

        function void clear_body();
            pair_phase = IN_KEY;
            esc_count = 2'd0;
            esc_digit = 8'd0;
            clear_key();
            num_phase = NUM_LEAD;
            num_neg = 1'b0;
            num_acc = 64'd0;
            num_sat = 1'b0;
            id_seen = 1'b0;
        endfunction

        function bit is_hex(logic [7:0] c);
            return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        endfunction

        function logic [3:0] hex_nibble(logic [7:0] c);
            if (c >= "0" && c <= "9")
                return 4'(c - "0");
            if (c >= "a" && c <= "f")
                return 4'(c - "a" + 8'd10);
            if (c >= "A" && c <= "F")
                return 4'(c - "A" + 8'd10);
            return 4'd0;
        endfunction

        function void key_char(logic [7:0] c);
            logic [7:0] want;
            if (key_cut)
                return;
            if (c == 8'd0)
            begin
                key_cut = 1'b1;
                return;
            end
            want = (key_pos == 2'd0) ? "i" : "d";
            if (key_pos >= 2'd2 || c != want)
                key_ok = 1'b0;
            if (key_pos < 2'd3)
                key_pos = key_pos + 2'd1;
        endfunction

        function void value_char(logic [7:0] c);
            logic [63:0] d;
            if (num_phase == NUM_BAD || num_phase == NUM_ENDED)
                return;
            if (c == 8'd0)
            begin
                num_phase = (num_phase == NUM_DIGITS) ? NUM_ENDED : NUM_BAD;
            end
            else if (c >= "0" && c <= "9")
            begin
                d = {56'd0, c} - 64'h30;
                num_phase = NUM_DIGITS;
                if (!num_sat)
                begin
                    if (num_acc > (ID_MAX - d) / 64'd10)
                    begin
                        num_acc = ID_MAX;
                        num_sat = 1'b1;
                    end
                    else
                    begin
                        num_acc = num_acc * 64'd10 + d;
                    end
                end
            end
            else if (num_phase == NUM_LEAD && (c == " " || (c >= 8'd9 && c <= 8'd13)))
            begin
                // leading whitespace is skipped
            end
            else if (num_phase == NUM_LEAD && (c == "+" || c == "-"))
            begin
                num_neg = (c == "-");
                num_phase = NUM_SIGNED;
            end
            else
            begin
                num_phase = NUM_BAD;
            end
        endfunction

        function void decoded_char(logic [7:0] c);
            if (pair_phase == IN_KEY)
                key_char(c);
            else if (pair_phase == IN_ID_VALUE)
                value_char(c);
        endfunction

        // A pending escape that never completed comes out as literal text.
        function void drain_escape();
            if (esc_count >= 2'd1)
                decoded_char("%");
            if (esc_count == 2'd2)
                decoded_char(esc_digit);
            esc_count = 2'd0;
            esc_digit = 8'd0;
        endfunction

        function void percent_decode(logic [7:0] b);
            logic [7:0] v;
            if (esc_count == 2'd1)
            begin
                if (is_hex(b))
                begin
                    esc_digit = b;
                    esc_count = 2'd2;
                    return;
                end
                drain_escape();
            end
            else if (esc_count == 2'd2)
            begin
                if (is_hex(b))
                begin
                    v = {hex_nibble(esc_digit), hex_nibble(b)};
                    esc_count = 2'd0;
                    esc_digit = 8'd0;
                    decoded_char(v);
                    return;
                end
                drain_escape();
            end
            if (b == "+")
                decoded_char(" ");
            else if (b == "%")
                esc_count = 2'd1;
            else
                decoded_char(b);
        endfunction

        function void raw_byte(logic [7:0] b);
            if (pair_phase == HALTED)
                return;
            if (b == 8'd0)
            begin
                drain_escape();
                pair_phase = HALTED;
            end
            else if (b == "&")
            begin
                if (pair_phase == IN_ID_VALUE)
                begin
                    drain_escape();
                    pair_phase = HALTED;
                end
                else
                begin
                    esc_count = 2'd0;
                    esc_digit = 8'd0;
                    clear_key();
                    pair_phase = IN_KEY;
                end
            end
            else if (b == "=" && pair_phase == IN_KEY)
            begin
                drain_escape();
                if (key_ok && key_pos == 2'd2)
                begin
                    id_seen = 1'b1;
                    pair_phase = IN_ID_VALUE;
                end
                else
                begin
                    pair_phase = IN_OTHER_VALUE;
                end
            end
            else if (pair_phase != IN_OTHER_VALUE)
            begin
                percent_decode(b);
            end
        endfunction

        function void note_byte(logic [7:0] b, bit fin);
            id_outcome_t got;
            bytes_seen++;
            raw_byte(b);
            if (!fin)
                return;
            if (pair_phase != HALTED)
                drain_escape();
            got.id_value = '0;
            if (!id_seen)
            begin
                got.status = ST_NO_ID;
                no_id_count++;
            end
            else if ((num_phase == NUM_DIGITS || num_phase == NUM_ENDED) && !num_neg &&
                     num_acc != 64'd0)
            begin
                got.status = ST_OK;
                got.id_value = num_acc[ID_W-1:0];
                ok_count++;
            end
            else
            begin
                got.status = ST_BAD;
                bad_count++;
            end
            outcomes.push_back(got);
            bodies_seen++;
            clear_body();
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH: %s", what);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [ID_W-1:0] idv);
            id_outcome_t want;
            if (outcomes.size() == 0)
            begin
                flag($sformatf("unexpected result status %0d id %0d", st, idv));
                return;
            end
            want = outcomes.pop_front();
            if (st !== want.status)
                flag($sformatf("status expected %0d actual %0d", want.status, st));
            if (idv !== want.id_value)
                flag($sformatf("id_value expected %0d actual %0d", want.id_value, idv));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   calm = 1'b0;
    int   cycles = 0;

    logic [7:0]     body_q[$];
    form_id_tracker tracker = new();

    ffid_body_if   body_ch();
    ffid_result_if result_ch();

    form_field_id_extractor u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .body  (body_ch),
        .result(result_ch)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout with %0d results outstanding", tracker.outcomes.size());
            $display("form_field_id_extractor_tb: errors");
            $finish;
        end
    end

    // Result side: check on handshake, then pick next ready.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            tracker.check_result(result_ch.status, result_ch.id_value);
        result_ch.ready <= calm || ($urandom_range(0, 99) >= 19);
    end

    task automatic send_byte(input logic [7:0] b, input bit fin);
        while (!calm && $urandom_range(0, 99) < 19)
        begin
            body_ch.valid <= 1'b0;
            @(posedge clk);
        end
        body_ch.valid   <= 1'b1;
        body_ch.in_byte <= b;
        body_ch.last    <= fin;
        @(posedge clk);
        while (!body_ch.ready)
            @(posedge clk);
        tracker.note_byte(b, fin);
    endtask

    task automatic send_body();
        if (body_q.size() == 0)
            body_q.push_back(8'($urandom_range(0, 255)));
        foreach (body_q[i])
            send_byte(body_q[i], i == body_q.size() - 1);
        body_q.delete();
    endtask

    task automatic put_byte(input logic [7:0] b);
        body_q.push_back(b);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            body_q.push_back(s[i]);
    endtask

    task automatic put_digits(input int n);
        for (int i = 0; i < n; i++)
            body_q.push_back(8'("0" + $urandom_range(0, 9)));
    endtask

    task automatic put_noise(input int n);
        for (int i = 0; i < n; i++)
            body_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic put_short_digits();
        if ($urandom_range(0, 3) == 0)
            put_digits($urandom_range(1, 19));
        else
            put_digits($urandom_range(1, 4));
    endtask

    task automatic put_key();
        case ($urandom_range(0, 11))
            0, 1, 2: put_text("id");
            3:       put_text("%69d");
            4:       put_text("i%64");
            5:       put_text("%69%64");
            6:
            begin
                put_text("id%00");
                put_noise($urandom_range(0, 2));
            end
            7:       put_text("idx");
            8:       put_text("i");
            9:       put_text("");
            10:
            begin
                if ($urandom_range(0, 1))
                    put_text("i+d");
                else
                    put_text("ID");
            end
            default: put_noise($urandom_range(1, 3));
        endcase
    endtask

    task automatic put_value();
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4: put_short_digits();
            5:
            begin
                if ($urandom_range(0, 1))
                    put_text("0");
                else
                    put_text("000");
            end
            6:
            begin
                if ($urandom_range(0, 1))
                    put_text("-");
                else
                    put_text("%2d");
                put_short_digits();
            end
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       put_text("+");
                    1:       put_text("%2B");
                    2:       put_text("%2b");
                    default: put_text("%2D");
                endcase
                put_short_digits();
            end
            8:
            begin
                repeat ($urandom_range(1, 3))
                begin
                    case ($urandom_range(0, 3))
                        0:       put_byte(8'($urandom_range(9, 13)));
                        1:       put_text(" ");
                        2:       put_text("+");
                        default: put_text("%20");
                    endcase
                end
                put_short_digits();
            end
            9:
            begin
                put_short_digits();
                put_text("%00");
                put_noise($urandom_range(0, 3));
            end
            10:
            begin
                put_short_digits();
                put_byte(8'($urandom_range(32, 126)));
            end
            11:
            begin
                if ($urandom_range(0, 2) == 0)
                    put_text("-");
                put_text("9");
                put_digits($urandom_range(18, 24));
            end
            12:
            begin
                put_text("922337203685477580");
                put_digits(1);
            end
            13:
            begin
                repeat ($urandom_range(1, 4))
                begin
                    put_text("%3");
                    put_digits(1);
                end
            end
            14:
            begin
                case ($urandom_range(0, 4))
                    0:       put_text("");
                    1:       put_text("+");
                    2:       put_text("-");
                    3:       put_text("%");
                    default:
                    begin
                        put_digits(1);
                        put_text("%3");
                    end
                endcase
            end
            default: put_noise($urandom_range(1, 4));
        endcase
    endtask

    task automatic make_random_body();
        int npairs;
        if ($urandom_range(0, 99) < 12)
        begin
            put_noise($urandom_range(1, 8));
            return;
        end
        npairs = $urandom_range(1, 4);
        for (int p = 0; p < npairs; p++)
        begin
            put_key();
            if ($urandom_range(0, 9) != 0)
            begin
                put_text("=");
                put_value();
            end
            if ($urandom_range(0, 19) == 0)
                put_byte(8'h00);
            if (p != npairs - 1)
                put_text("&");
        end
        case ($urandom_range(0, 11))
            0:       put_text("&");
            1:       put_text("%");
            2:       put_text("%4");
            3:       put_text("=");
            4:
            begin
                put_byte(8'h00);
                put_noise($urandom_range(0, 3));
            end
            5:
            begin
                put_text("&id=");
                put_digits(2);
            end
            default: ;
        endcase
    endtask

    initial
    begin
        int nbody;
        body_ch.valid   = 1'b0;
        body_ch.in_byte = 8'd0;
        body_ch.last    = 1'b0;
        result_ch.ready = 1'b0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed bodies
        put_text("id=42");                                   send_body();
        put_text("a=1&id=%2B7");                             send_body();
        put_text("id=0");                                    send_body();
        put_text("id=-3");                                   send_body();
        put_text("id=");                                     send_body();
        put_text("x");                                       send_body();
        put_text("id=9223372036854775807");                  send_body();
        put_text("id=99999999999999999999");                 send_body();
        put_text("id=-99999999999999999999");                send_body();
        put_text("%69%64= ");  put_byte(8'd9);  put_text("5"); send_body();
        put_text("id%00zz=9");                               send_body();
        put_text("id=12%00x");                               send_body();
        put_text("id=12x");                                  send_body();
        put_text("id&id=5&id=6");                            send_body();
        put_text("id=7&");  put_noise(3);                    send_body();
        put_text("a=1");  put_byte(8'h00);  put_text("&id=3"); send_body();
        put_text("id=%4");                                   send_body();
        put_text("id%=1&i+d=2&id=%3");                       send_body();
        put_text("q=%FF&id=1");  put_byte(8'hFF);            send_body();
        put_byte(8'hA5);                                     send_body();

        // random bodies, with a stretch where neither side idles
        nbody = 0;
        while (tracker.bytes_seen < 1100)
        begin
            calm = (nbody >= 30 && nbody < 60);
            make_random_body();
            send_body();
            nbody++;
        end
        calm = 1'b0;
        body_ch.valid <= 1'b0;

        while (tracker.outcomes.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);

        $display("sent %0d bodies in %0d bytes; outcomes: %0d valid id, %0d no id, %0d invalid",
                 tracker.bodies_seen, tracker.bytes_seen, tracker.ok_count,
                 tracker.no_id_count, tracker.bad_count);
        if (tracker.mismatches == 0 && tracker.outcomes.size() == 0)
        begin
            $display("form_field_id_extractor_tb: clean");
        end
        else
        begin
            $display("%0d mismatches", tracker.mismatches);
            $display("form_field_id_extractor_tb: errors");
        end
        $finish;
    end

endmodule
